/* design/arnsf_pkg.sv */
// Shared types and constants for the autoregressive noise synthesis filter.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package arnsf_pkg;

  localparam int MAX_ORDER     = 6;
  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int COEF_FRAC     = 12;
  localparam int ORDER_BITS    = 3;
  localparam int CNT_BITS      = 3;
  localparam int IDX_BITS      = 3;
  localparam int HIST_IDX_BITS = $clog2(MAX_ORDER);
  localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS      = PROD_BITS + $clog2(MAX_ORDER + 2);

  localparam logic [CNT_BITS-1:0] WARMUP_MAX = '1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef sample_t [MAX_ORDER-1:0]       sample_vec_t;
  typedef coef_t   [MAX_ORDER-1:0]       coef_vec_t;

  typedef struct packed {
    logic [ORDER_BITS-1:0] order;
    coef_vec_t             coef;
  } filt_cfg_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ORDER,
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C,
    REG_COEF_D,
    REG_COEF_E,
    REG_COEF_F
  } reg_index_t;

endpackage

/* design/arnsf_cfg_regs.sv */
// Configuration register file: filter order (stored clamped) and coefficients.
// Depends on arnsf_pkg.
`timescale 1ns / 1ps

module arnsf_cfg_regs import arnsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_BITS-1:0]    cfg_index,
  input  logic [COEF_BITS-1:0]   cfg_data,
  output filt_cfg_t              cfg
);

  logic [ORDER_BITS-1:0] order_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    order_next = cfg_data[ORDER_BITS-1:0];
    if (order_next == '0) begin
      order_next = ORDER_BITS'(1);
    end else if (order_next > ORDER_BITS'(MAX_ORDER)) begin
      order_next = ORDER_BITS'(MAX_ORDER);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order <= ORDER_BITS'(1);
      cfg.coef  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ORDER) begin
        cfg.order <= order_next;
      end else if (cfg_index >= REG_COEF_A && cfg_index <= REG_COEF_F) begin
        cfg.coef[HIST_IDX_BITS'(cfg_index - IDX_BITS'(REG_COEF_A))] <= cfg_data;
      end
    end
  end

endmodule

/* design/arnsf_mac.sv */
// Single-pass filter arithmetic: parallel products, sum, rounding, saturation,
// and warm-up pass-through. Depends on arnsf_pkg.
`timescale 1ns / 1ps

module arnsf_mac import arnsf_pkg::*; (
  input  sample_t               innovation,
  input  logic                  restart,
  input  logic [CNT_BITS-1:0]   warmup_count,
  input  sample_vec_t           history,
  input  filt_cfg_t             cfg,
  output sample_t               noise_sample,
  output logic                  clipped
);

  localparam int Q_BITS = ACC_BITS - COEF_FRAC;
  localparam logic signed [Q_BITS-1:0] SAT_HI = Q_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [Q_BITS-1:0] SAT_LO = Q_BITS'(-(2 ** (SAMPLE_BITS - 1)));

  logic signed [PROD_BITS-1:0] prod [MAX_ORDER];
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_rnd;
  logic signed [Q_BITS-1:0]    q;
  logic                        warm;

  always_comb begin
    warm = restart ||
           ({1'b0, warmup_count} < ({1'b0, cfg.order} + (CNT_BITS + 1)'(1)));
    acc = ACC_BITS'(innovation) <<< COEF_FRAC;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (ORDER_BITS'(i) < cfg.order) begin
        prod[i] = $signed(cfg.coef[i]) * $signed(history[i]);
      end else begin
        prod[i] = '0;
      end
      acc = acc + ACC_BITS'(prod[i]);
    end
    acc_rnd = acc + ACC_BITS'(2 ** (COEF_FRAC - 1));
    q = Q_BITS'(acc_rnd >>> COEF_FRAC);

    clipped = 1'b0;
    priority if (warm) begin
      noise_sample = innovation;
    end else if (q > SAT_HI) begin
      noise_sample = SAMPLE_BITS'(SAT_HI);
      clipped      = 1'b1;
    end else if (q < SAT_LO) begin
      noise_sample = SAMPLE_BITS'(SAT_LO);
      clipped      = 1'b1;
    end else begin
      noise_sample = SAMPLE_BITS'(q);
    end
  end

endmodule

/* design/ar_noise_synthesis_filter_unit.sv */
// Top level of the autoregressive noise synthesis filter: handshake pipeline,
// output history and warm-up counter. Depends on arnsf_pkg, arnsf_cfg_regs, arnsf_mac.
`timescale 1ns / 1ps

// Takes one innovation item per cycle and returns one noise item per cycle while
// the receiver does not stall; each item passes through the input register, then
// the result register. The recursion closes through the output history register:
// six 16x16 multipliers and their sum feed the result register and the output
// history together. A restart item clears the history and passes through, as do
// the following samples until order+1 have gone by. Configuration writes are
// always ready and must be made while no item is in flight.
module ar_noise_synthesis_filter_unit import arnsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  innov_valid,
  output logic                  innov_stall,
  input  sample_t               innovation,
  input  logic                  restart,
  output logic                  noise_valid,
  input  logic                  noise_stall,
  output sample_t               noise_sample,
  output logic                  clipped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [COEF_BITS-1:0]  cfg_data
);

  filt_cfg_t             cfg;
  logic                  s1_valid;
  sample_t               s1_innovation;
  logic                  s1_restart;
  sample_vec_t           history;
  sample_vec_t           history_next;
  logic [CNT_BITS-1:0]   warmup_count;
  logic [CNT_BITS-1:0]   warmup_count_next;
  sample_t               y;
  logic                  y_clip;
  logic                  advance;
  logic                  fire;

  arnsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arnsf_mac u_mac (
    .innovation   (s1_innovation),
    .restart      (s1_restart),
    .warmup_count (warmup_count),
    .history      (history),
    .cfg          (cfg),
    .noise_sample (y),
    .clipped      (y_clip)
  );

  assign advance     = !noise_valid || !noise_stall;
  assign fire        = s1_valid && advance;
  assign innov_stall = s1_valid && !advance;

  always_comb begin
    if (s1_restart) begin
      history_next      = '0;
      history_next[0]   = y;
      warmup_count_next = CNT_BITS'(1);
    end else begin
      history_next      = {history[MAX_ORDER-2:0], y};
      warmup_count_next = (warmup_count == WARMUP_MAX) ? warmup_count
                                                       : warmup_count + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      noise_valid  <= 1'b0;
      history      <= '0;
      warmup_count <= '0;
    end else begin
      if (!innov_stall) begin
        s1_valid <= innov_valid;
      end
      if (advance) begin
        noise_valid <= s1_valid;
      end
      if (fire) begin
        history      <= history_next;
        warmup_count <= warmup_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (innov_valid && !innov_stall) begin
      s1_innovation <= innovation;
      s1_restart    <= restart;
    end
    if (fire) begin
      noise_sample <= y;
      clipped      <= y_clip;
    end
  end

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    noise_valid && clipped |->
      (noise_sample == sample_t'(2 ** (SAMPLE_BITS - 1) - 1)) ||
      (noise_sample == sample_t'(-(2 ** (SAMPLE_BITS - 1)))))
    else $error("clipped item not at a saturation rail");

  a_restart_passes: assert property (@(posedge clk) disable iff (rst)
    fire && s1_restart |=> !clipped && noise_sample == $past(s1_innovation))
    else $error("restart item did not pass through");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    fire |=> warmup_count != '0 && history[0] == noise_sample)
    else $error("history or warm-up count not advanced with item");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    innov_stall |-> s1_valid && noise_valid)
    else $error("input stalled with a free pipeline slot");

endmodule

/* verif/ar_noise_synthesis_filter_unit_tb.sv */
// Testbench for ar_noise_synthesis_filter_unit: random bursts of innovation items, checked
// against an in-bench predictor of the autoregressive recursion, with saturation and warm-up.
// Depends on arnsf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module ar_noise_synthesis_filter_unit_tb;
  import arnsf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 123;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [IDX_BITS-1:0] REG_SPARE = IDX_BITS'(MAX_ORDER + 1);
  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t x;
    logic    r;
  } innov_item_t;

  typedef struct packed {
    sample_t sample;
    logic    clip;
  } noise_exp_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;
  typedef enum int {COEF_MILD, COEF_MODERATE, COEF_FULL} coef_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 innov_valid = 1'b0;
  logic                 innov_stall;
  sample_t              innovation = '0;
  logic                 restart = 1'b0;
  logic                 noise_valid;
  logic                 noise_stall = 1'b0;
  sample_t              noise_sample;
  logic                 clipped;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index = '0;
  logic [COEF_BITS-1:0] cfg_data = '0;

  // predictor state
  logic [ORDER_BITS-1:0] filt_order = ORDER_BITS'(1);
  coef_t                 filt_coef [MAX_ORDER] = '{default: '0};
  sample_t               past_out [MAX_ORDER] = '{default: '0};
  logic [CNT_BITS-1:0]   warm_cnt = '0;

  innov_item_t innov_backlog [$];
  noise_exp_t  noise_due [$];
  innov_item_t cur_item;
  noise_exp_t  want;
  logic        in_taken = 1'b0;
  int          items_queued = 0;
  int          items_accepted = 0;
  int          items_checked = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  ar_noise_synthesis_filter_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic noise_exp_t ar_synth(input sample_t x, input logic rs);
    noise_exp_t res;
    int         eff;
    int         i;
    longint     acc;
    longint     y;
    eff = (filt_order == 0) ? 1 : (filt_order > MAX_ORDER) ? MAX_ORDER : int'(filt_order);
    if (rs) begin
      foreach (past_out[j]) past_out[j] = '0;
      warm_cnt = '0;
    end
    res.clip = 1'b0;
    if (warm_cnt < eff + 1) begin
      y = x;
    end else begin
      acc = longint'(x) * (longint'(1) << COEF_FRAC);
      for (i = 0; i < eff; i++) acc += longint'(filt_coef[i]) * longint'(past_out[i]);
      y = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (y > longint'(SMP_MAX)) begin
        y = SMP_MAX;
        res.clip = 1'b1;
      end
      if (y < longint'(SMP_MIN)) begin
        y = SMP_MIN;
        res.clip = 1'b1;
      end
    end
    for (i = MAX_ORDER - 1; i > 0; i--) past_out[i] = past_out[i-1];
    past_out[0] = sample_t'(y);
    if (warm_cnt != WARMUP_MAX) warm_cnt++;
    res.sample = sample_t'(y);
    return res;
  endfunction

  function automatic sample_t rand_innovation();
    case ($urandom_range(0, 19))
      0, 1, 2: return sample_t'($urandom);
      3:       return SMP_MAX;
      4:       return SMP_MIN;
      5:       return sample_t'(int'($urandom_range(0, 2)) - 1);
      default: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic coef_t rand_coef(input coef_style_t style);
    case (style)
      COEF_MILD:     return coef_t'(int'($urandom_range(0, 2048)) - 1024);
      COEF_MODERATE: return coef_t'(int'($urandom_range(0, 8192)) - 4096);
      default:       return coef_t'($urandom);
    endcase
  endfunction

  task automatic add_item(input sample_t x, input logic r);
    innov_item_t entry;
    entry = '{x: x, r: r};
    innov_backlog = {innov_backlog, entry};
    items_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_checked != items_queued);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      innov_valid <= 1'b0;
    end else if (!innov_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        innov_valid <= 1'b0;
      end else if (innov_backlog.size() > 0) begin
        cur_item = innov_backlog.pop_front();
        innov_valid <= 1'b1;
        innovation  <= cur_item.x;
        restart     <= cur_item.r;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        innov_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off while the sender keeps offering
  always @(negedge clk) begin
    if (rst) begin
      noise_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      noise_stall <= 1'b1;
    end else if (!hold_done && items_accepted >= 400 && innov_backlog.size() > 50) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      noise_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:    noise_stall <= 1'b0;
        STALL_LIGHT:   noise_stall <= ($urandom_range(0, 3) == 0);
        STALL_PATTERN: noise_stall <= (cycle_cnt % 3 == 0);
        default:       noise_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: register writes, accepted items, result checks
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= innov_valid && !innov_stall;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ORDER) begin
          filt_order = cfg_data[ORDER_BITS-1:0];
        end else if (cfg_index >= REG_COEF_A && cfg_index <= REG_COEF_F) begin
          filt_coef[cfg_index - REG_COEF_A] = coef_t'(cfg_data);
        end
      end
      if (innov_valid && !innov_stall) begin
        noise_due = {noise_due, ar_synth(innovation, restart)};
        items_accepted++;
      end
      if (noise_valid && !noise_stall) begin
        if (noise_due.size() == 0) begin
          $display("%0t unexpected item: noise_sample %0d clipped %0b",
                   $time, noise_sample, clipped);
          errors++;
        end else begin
          want = noise_due.pop_front();
          if (noise_sample !== want.sample) begin
            $display("%0t noise_sample mismatch: expected %0d, actual %0d",
                     $time, want.sample, noise_sample);
            errors++;
          end
          if (clipped !== want.clip) begin
            $display("%0t clipped mismatch: expected %0b, actual %0b",
                     $time, want.clip, clipped);
            errors++;
          end
          items_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int                    p;
    int                    k;
    logic [ORDER_BITS-1:0] ord;
    coef_t                 c;
    coef_style_t           cs;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: order 1, zero coefficients, warm-up from reset
    add_item(sample_t'(100), 1'b0);
    add_item(sample_t'(-5), 1'b0);
    add_item(SMP_MAX, 1'b0);
    add_item(SMP_MIN, 1'b0);
    wait_drained();

    write_reg(REG_ORDER, 16'hFFFA);
    write_reg(REG_COEF_A, COEF_MAX);
    write_reg(REG_COEF_B, COEF_MIN);
    write_reg(REG_SPARE, 16'h5A5A);
    add_item(SMP_MAX, 1'b1);
    add_item(SMP_MAX, 1'b0);
    add_item(SMP_MAX, 1'b0);
    add_item(SMP_MAX, 1'b0);
    add_item(SMP_MIN, 1'b0);
    add_item(SMP_MIN, 1'b0);
    add_item(sample_t'(0), 1'b0);
    add_item(sample_t'(1), 1'b0);
    add_item(sample_t'(-1), 1'b0);
    add_item(sample_t'(-1), 1'b1);
    wait_drained();

    // order zero behaves as one
    write_reg(REG_ORDER, 16'hFFF8);
    write_reg(REG_COEF_A, 16'h1000);
    add_item(sample_t'(7), 1'b1);
    for (k = 0; k < 3; k++) add_item(sample_t'(7), 1'b0);
    add_item(sample_t'(-3), 1'b0);
    wait_drained();

    // order seven behaves as six
    write_reg(REG_ORDER, 16'h0007);
    for (k = 0; k < MAX_ORDER; k++) write_reg(IDX_BITS'(REG_COEF_A + k), 16'hF000);
    add_item(sample_t'(1000), 1'b1);
    for (k = 0; k < 7; k++) add_item(sample_t'(1000 - 300 * k), 1'b0);
    wait_drained();

    for (p = 0; p < RAND_PHASES; p++) begin
      ord = (p < 2) ? ORDER_BITS'(MAX_ORDER) : ORDER_BITS'($urandom_range(0, 7));
      cs = coef_style_t'($urandom_range(0, 2));
      write_reg(REG_ORDER, {13'($urandom), ord});
      for (k = 0; k < MAX_ORDER; k++) begin
        c = (p == 0) ? COEF_MAX : (p == 1) ? COEF_MIN : rand_coef(cs);
        write_reg(IDX_BITS'(REG_COEF_A + k), c);
      end
      if ($urandom_range(0, 1)) write_reg(REG_SPARE, 16'($urandom));
      for (k = 0; k < PHASE_ITEMS; k++) add_item(rand_innovation(), $urandom_range(0, 31) == 0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
